/* rtl/core/gpc_pkg.sv */
package gpc_pkg;

    // Default parameter values
    localparam int COORD_FRAC_BITS_DEF  = 16;
    localparam int CURSOR_FRAC_BITS_DEF = 8;
    localparam int SCREEN_BITS_DEF      = 13;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;
    localparam int SCR_CFG_W  = 14;
    localparam int DIST_CFG_W = 17;
    localparam int HOLD_CFG_W = 10;
    localparam int WHEEL_W    = 10;
    localparam int WHEEL_MAX  = 480;
    localparam int TIME_W     = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_PINCH_ENTER   = 3'd2,
        REG_PINCH_EXIT    = 3'd3,
        REG_PRESS_HOLD    = 3'd4,
        REG_RELEASE_HOLD  = 3'd5,
        REG_SCROLL_DEAD   = 3'd6,
        REG_UNUSED        = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_CURSOR = 2'd1,
        MODE_SCROLL = 2'd2,
        MODE_SPARE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        EV_BUTTON_DOWN = 2'd0,
        EV_BUTTON_UP   = 2'd1,
        EV_MOVE        = 2'd2,
        EV_WHEEL       = 2'd3
    } event_kind_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FRONT,
        ST_PINCH_DX,
        ST_PINCH_DY,
        ST_PINCH_EN,
        ST_PINCH_EX,
        ST_PINCH_DEC,
        ST_FREEZE,
        ST_MOT_DX,
        ST_MOT_DY,
        ST_MOT_SUM,
        ST_SQRT,
        ST_ACC_X,
        ST_ACC_Y,
        ST_TGT_X,
        ST_TGT_Y,
        ST_BLEND_X,
        ST_BLEND_Y,
        ST_MOVE,
        ST_SCROLL,
        ST_WHEEL_MUL,
        ST_WHEEL,
        ST_OUT
    } state_t;

endpackage

/* rtl/core/gesture_pointer_controller_unit.sv */
// Channel | Direction | Payload
// s_      | in        | tuser: gesture_mode; tdata: index/thumb points, flags, now_ms
// m_      | out       | tuser: event_kind; tdata: pointer_x/y, wheel; tlast: last_event
// cfg_    | in        | cfg_addr register index, cfg_data write data (always ready)
//
// The time from one frame's accept to the next accept is set by the shared
// multiplier (one product per cycle, registered), the one-bit-per-cycle square root
// and the taking of each result word.
// The next frame is taken once every result word of the current frame is taken.
// Reset: synchronous, active low; clears the tracking state and restores defaults.
// A stall on m_ holds the result word; s_tready stays low meanwhile.
module gesture_pointer_controller_unit #(
    parameter int COORD_FRAC_BITS  = gpc_pkg::COORD_FRAC_BITS_DEF,
    parameter int CURSOR_FRAC_BITS = gpc_pkg::CURSOR_FRAC_BITS_DEF,
    parameter int SCREEN_BITS      = gpc_pkg::SCREEN_BITS_DEF,
    localparam int IN_BITS = 4 * (COORD_FRAC_BITS + 1) + 2 + gpc_pkg::TIME_W,
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 2 * SCREEN_BITS + gpc_pkg::WHEEL_W,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // tdata: index_x, index_y, thumb_x, thumb_y, index_ok, thumb_ok, now_ms
    input  logic [IN_W-1:0]                 s_tdata,
    // tuser: gesture_mode
    input  logic [1:0]                      s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata: pointer_x, pointer_y, wheel_amount
    output logic [OUT_W-1:0]                m_tdata,
    // tuser: event_kind
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gpc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [gpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gpc_pkg::*;

    localparam int F      = COORD_FRAC_BITS;
    localparam int C      = CURSOR_FRAC_BITS;
    localparam int S      = SCREEN_BITS;
    localparam int CW     = F + 1;
    localparam int DW     = CW + 1;
    localparam int RW     = F + 1;
    localparam int D2W    = 2 * RW;
    localparam int MW0    = (F + 8 > S + C + 2) ? F + 8 : S + C + 2;
    localparam int MW     = (MW0 > DIST_CFG_W + 1) ? MW0 : DIST_CFG_W + 1;
    localparam int PRW    = 2 * MW;
    localparam int PW     = PRW + C + 1;
    localparam int CUR_W  = S + C;
    localparam int SCR_W  = S + 1;
    localparam int CNT_W  = $clog2(RW);
    localparam int ONE    = 1 << F;
    localparam int SCR_MAX = 1 << S;
    localparam int AMIN   = (15 * ONE + 50) / 100;
    localparam longint MOVE_MIN = ((64'd1 << (2 * F)) + 64'd3999999) / 64'd4000000;

    // half-away-from-zero rounding right shift
    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
                                                 input int s);
        logic [PW-1:0] mag;
        logic [PW-1:0] half;
        mag  = v[PW-1] ? PW'(-v) : PW'(v);
        half = (PW'(1) << s) >> 1;
        mag  = (mag + half) >> s;
        return v[PW-1] ? -$signed(mag) : $signed(mag);
    endfunction

    state_t state_reg, state_next;

    // frame word
    logic [1:0]        mode_in_reg, mode_in_next;
    logic [CW-1:0]     ix_reg, iy_reg, tx_reg, ty_reg;
    logic [CW-1:0]     ix_next, iy_next, tx_next, ty_next;
    logic              iok_reg, tok_reg, iok_next, tok_next;
    logic [TIME_W-1:0] now_reg, now_next;

    // tracking state
    logic [1:0]        active_reg, active_next;
    logic              held_reg, held_next;
    logic [TIME_W-1:0] freeze_reg, freeze_next;
    logic              first_reg, first_next;
    logic              primed_reg, primed_next;
    logic [CW-1:0]     lscroll_reg, lscroll_next;
    logic [CW-1:0]     lrx_reg, lry_reg, lrx_next, lry_next;
    logic [CUR_W-1:0]  curx_reg, cury_reg, curx_next, cury_next;

    // configuration
    logic [SCR_CFG_W-1:0]  cw_reg, ch_reg;
    logic [DIST_CFG_W-1:0] cen_reg, cex_reg, cdz_reg;
    logic [HOLD_CFG_W-1:0] cph_reg, crh_reg;

    // shared arithmetic
    logic signed [MW-1:0]  mul_a, mul_b;
    logic signed [PRW-1:0] prod_reg, prod_next, sum_reg, sum_next;
    logic signed [DW-1:0]  dx_reg, dy_reg, dx_next, dy_next;
    logic [RW-1:0]         m_reg, m_next;
    logic [RW+1:0]         rem_reg, rem_next;
    logic [D2W-1:0]        rad_reg, rad_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic signed [MW-1:0]  t1x_reg, t1y_reg, t1x_next, t1y_next;
    logic [CUR_W-1:0]      tgx_reg, tgy_reg, tgx_next, tgy_next;
    logic                  lt_reg, lt_next;

    // result buffer
    logic [1:0]         ev_kind_reg [2];
    logic [S-1:0]       ev_px_reg   [2];
    logic [S-1:0]       ev_py_reg   [2];
    logic [WHEEL_W-1:0] ev_wh_reg   [2];
    logic [1:0]         ev_cnt_reg, ev_cnt_next;
    logic               out_idx_reg, out_idx_next;

    logic               push;
    event_kind_t        push_kind;
    logic [S-1:0]       push_px, push_py;
    logic [WHEEL_W-1:0] push_wh;

    // derived values
    logic [1:0]         mode_eff;
    logic               mode_chg, iv, tv, frozen, s_acc, m_acc, out_last;
    logic [SCR_W-1:0]   w_eff, h_eff;
    logic [SCR_W+1:0]   w3, h3;
    logic [CUR_W-1:0]   hi_x, hi_y;
    logic [RW+3:0]      m15;
    logic [F:0]         alpha;
    logic [RW+5:0]      acc;
    logic [TIME_W:0]    fz_press, fz_release;
    logic signed [PRW-1:0] m2;
    logic [RW+3:0]      sq_shift;
    logic [RW+4:0]      sq_diff;
    logic signed [PW-1:0]  r_t, v_t, r_b;
    logic signed [DW-1:0]  d_sc;
    logic signed [DW:0]    d_abs;
    logic [CUR_W:0]        px_w, py_w;

    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;
    assign out_last  = (2'(out_idx_reg) == ev_cnt_reg - 2'd1);

    // frame-level decode
    always_comb begin
        mode_eff = (mode_in_reg == MODE_SPARE) ? MODE_IDLE : mode_in_reg;
        mode_chg = (mode_eff != active_reg);
        iv = iok_reg && (ix_reg <= CW'(ONE)) && (iy_reg <= CW'(ONE));
        tv = tok_reg && (tx_reg <= CW'(ONE)) && (ty_reg <= CW'(ONE));
        frozen = (now_reg < freeze_reg);
        if (cw_reg == '0) w_eff = SCR_W'(1);
        else if (32'(cw_reg) > SCR_MAX) w_eff = SCR_W'(SCR_MAX);
        else w_eff = SCR_W'(cw_reg);
        if (ch_reg == '0) h_eff = SCR_W'(1);
        else if (32'(ch_reg) > SCR_MAX) h_eff = SCR_W'(SCR_MAX);
        else h_eff = SCR_W'(ch_reg);
        w3 = {w_eff, 1'b0} + (SCR_W+2)'(w_eff);
        h3 = {h_eff, 1'b0} + (SCR_W+2)'(h_eff);
        hi_x = CUR_W'(w_eff - SCR_W'(1)) << C;
        hi_y = CUR_W'(h_eff - SCR_W'(1)) << C;
        m15 = ((RW+4)'(m_reg) << 4) - (RW+4)'(m_reg);
        if (m15 < (RW+4)'(AMIN)) alpha = (F+1)'(AMIN);
        else if (m15 > (RW+4)'(ONE)) alpha = (F+1)'(ONE);
        else alpha = (F+1)'(m15);
        acc = (RW+6)'(ONE) + ((RW+6)'(m_reg) << 5) + ((RW+6)'(m_reg) << 3);
        fz_press   = (TIME_W+1)'(now_reg) + (TIME_W+1)'(cph_reg);
        fz_release = (TIME_W+1)'(now_reg) + (TIME_W+1)'(crh_reg);
        m2 = sum_reg + prod_reg;
        sq_shift = {rem_reg, rad_reg[D2W-1:D2W-2]};
        sq_diff = {1'b0, sq_shift} - (RW+5)'({m_reg, 2'b01});
        r_t = rnd(PW'(prod_reg) <<< C, F + 1);
        r_b = rnd(PW'(prod_reg), F);
        // vertical scroll delta against the last recorded position
        d_sc = $signed({1'b0, lscroll_reg}) - $signed({1'b0, iy_reg});
        d_abs = d_sc[DW-1] ? -(DW+1)'(d_sc) : (DW+1)'(d_sc);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_acc) state_next = ST_FRONT;
            ST_FRONT: begin
                if (!iv || mode_eff == MODE_IDLE) state_next = ST_OUT;
                else if (mode_eff == MODE_CURSOR) state_next = tv ? ST_PINCH_DX : ST_FREEZE;
                else state_next = ST_SCROLL;
            end
            ST_PINCH_DX:  state_next = ST_PINCH_DY;
            ST_PINCH_DY:  state_next = ST_PINCH_EN;
            ST_PINCH_EN:  state_next = ST_PINCH_EX;
            ST_PINCH_EX:  state_next = ST_PINCH_DEC;
            ST_PINCH_DEC: state_next = ST_FREEZE;
            ST_FREEZE:    state_next = (frozen || first_reg) ? ST_OUT : ST_MOT_DX;
            ST_MOT_DX:    state_next = ST_MOT_DY;
            ST_MOT_DY:    state_next = ST_MOT_SUM;
            ST_MOT_SUM:   state_next = (m2 < PRW'(MOVE_MIN)) ? ST_OUT : ST_SQRT;
            ST_SQRT:      if (cnt_reg == CNT_W'(RW - 1)) state_next = ST_ACC_X;
            ST_ACC_X:     state_next = ST_ACC_Y;
            ST_ACC_Y:     state_next = ST_TGT_X;
            ST_TGT_X:     state_next = ST_TGT_Y;
            ST_TGT_Y:     state_next = ST_BLEND_X;
            ST_BLEND_X:   state_next = ST_BLEND_Y;
            ST_BLEND_Y:   state_next = ST_MOVE;
            ST_MOVE:      state_next = ST_OUT;
            ST_SCROLL: begin
                if (!primed_reg) state_next = ST_OUT;
                else if (18'(d_abs) < 18'(cdz_reg)) state_next = ST_OUT;
                else state_next = ST_WHEEL_MUL;
            end
            ST_WHEEL_MUL: state_next = ST_WHEEL;
            ST_WHEEL:     state_next = ST_OUT;
            ST_OUT: begin
                if (ev_cnt_reg == 2'd0) state_next = ST_IDLE;
                else if (m_acc && out_last) state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        mode_in_next = mode_in_reg;
        ix_next = ix_reg; iy_next = iy_reg; tx_next = tx_reg; ty_next = ty_reg;
        iok_next = iok_reg; tok_next = tok_reg; now_next = now_reg;
        active_next = active_reg; held_next = held_reg; freeze_next = freeze_reg;
        first_next = first_reg; primed_next = primed_reg; lscroll_next = lscroll_reg;
        lrx_next = lrx_reg; lry_next = lry_reg; curx_next = curx_reg; cury_next = cury_reg;
        sum_next = sum_reg; dx_next = dx_reg; dy_next = dy_reg; m_next = m_reg;
        rem_next = rem_reg; rad_next = rad_reg; cnt_next = cnt_reg;
        t1x_next = t1x_reg; t1y_next = t1y_reg; tgx_next = tgx_reg; tgy_next = tgy_reg;
        lt_next = lt_reg; out_idx_next = out_idx_reg;
        mul_a = '0; mul_b = '0;
        push = 1'b0; push_kind = EV_MOVE; push_px = '0; push_py = '0; push_wh = '0;
        v_t = '0;
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT) && (ev_cnt_reg != 2'd0);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    mode_in_next = s_tuser;
                    ix_next  = s_tdata[CW-1:0];
                    iy_next  = s_tdata[2*CW-1:CW];
                    tx_next  = s_tdata[3*CW-1:2*CW];
                    ty_next  = s_tdata[4*CW-1:3*CW];
                    iok_next = s_tdata[4*CW];
                    tok_next = s_tdata[4*CW+1];
                    now_next = s_tdata[4*CW+2+TIME_W-1:4*CW+2];
                end
            end
            ST_FRONT: begin
                // mode change or idle/invalid index releases the button
                if (held_reg && (mode_chg || !iv || mode_eff == MODE_IDLE)) begin
                    push = 1'b1; push_kind = EV_BUTTON_UP; held_next = 1'b0;
                end
                if (mode_chg) begin
                    active_next = mode_eff; first_next = 1'b1; primed_next = 1'b0;
                end
                dx_next = $signed({1'b0, tx_reg}) - $signed({1'b0, ix_reg});
                dy_next = $signed({1'b0, ty_reg}) - $signed({1'b0, iy_reg});
            end
            ST_PINCH_DX: begin mul_a = MW'(dx_reg); mul_b = MW'(dx_reg); end
            ST_PINCH_DY: begin sum_next = prod_reg; mul_a = MW'(dy_reg); mul_b = MW'(dy_reg); end
            ST_PINCH_EN: begin
                sum_next = sum_reg + prod_reg;
                mul_a = MW'($signed({1'b0, cen_reg})); mul_b = MW'($signed({1'b0, cen_reg}));
            end
            ST_PINCH_EX: begin
                lt_next = (sum_reg < prod_reg);
                mul_a = MW'($signed({1'b0, cex_reg})); mul_b = MW'($signed({1'b0, cex_reg}));
            end
            ST_PINCH_DEC: begin
                // hysteresis: press below enter, release above exit
                if (lt_reg && !held_reg) begin
                    push = 1'b1; push_kind = EV_BUTTON_DOWN; held_next = 1'b1;
                    freeze_next = fz_press[TIME_W] ? '1 : fz_press[TIME_W-1:0];
                end else if ((sum_reg > prod_reg) && held_reg) begin
                    push = 1'b1; push_kind = EV_BUTTON_UP; held_next = 1'b0;
                    freeze_next = fz_release[TIME_W] ? '1 : fz_release[TIME_W-1:0];
                end
            end
            ST_FREEZE: begin
                if (!frozen && first_reg) begin
                    curx_next = CUR_W'(w_eff >> 1) << C;
                    cury_next = CUR_W'(h_eff >> 1) << C;
                    first_next = 1'b0;
                end
                dx_next = $signed({1'b0, ix_reg}) - $signed({1'b0, lrx_reg});
                dy_next = $signed({1'b0, iy_reg}) - $signed({1'b0, lry_reg});
                lrx_next = ix_reg; lry_next = iy_reg;
            end
            ST_MOT_DX: begin mul_a = MW'(dx_reg); mul_b = MW'(dx_reg); end
            ST_MOT_DY: begin sum_next = prod_reg; mul_a = MW'(dy_reg); mul_b = MW'(dy_reg); end
            ST_MOT_SUM: begin
                rad_next = D2W'(m2); rem_next = '0; m_next = '0; cnt_next = '0;
            end
            ST_SQRT: begin
                // restoring square root, one result bit per cycle
                if (!sq_diff[RW+4]) begin
                    rem_next = sq_diff[RW+1:0]; m_next = {m_reg[RW-2:0], 1'b1};
                end else begin
                    rem_next = sq_shift[RW+1:0]; m_next = {m_reg[RW-2:0], 1'b0};
                end
                rad_next = rad_reg << 2;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_ACC_X: begin mul_a = MW'(dx_reg); mul_b = MW'($signed({1'b0, acc})); end
            ST_ACC_Y: begin
                t1x_next = MW'(r_b);
                mul_a = MW'(dy_reg); mul_b = MW'($signed({1'b0, acc}));
            end
            ST_TGT_X: begin
                t1y_next = MW'(r_b);
                mul_a = t1x_reg; mul_b = MW'($signed({1'b0, w3}));
            end
            ST_TGT_Y: begin
                v_t = PW'($signed({1'b0, curx_reg})) + r_t;
                if (v_t < 0) tgx_next = '0;
                else if (v_t > PW'($signed({1'b0, hi_x}))) tgx_next = hi_x;
                else tgx_next = CUR_W'(v_t);
                mul_a = t1y_reg; mul_b = MW'($signed({1'b0, h3}));
            end
            ST_BLEND_X: begin
                v_t = PW'($signed({1'b0, cury_reg})) + r_t;
                if (v_t < 0) tgy_next = '0;
                else if (v_t > PW'($signed({1'b0, hi_y}))) tgy_next = hi_y;
                else tgy_next = CUR_W'(v_t);
                mul_a = MW'($signed({1'b0, alpha}));
                mul_b = MW'($signed({1'b0, tgx_reg}) - $signed({1'b0, curx_reg}));
            end
            ST_BLEND_Y: begin
                curx_next = CUR_W'(PW'($signed({1'b0, curx_reg})) + r_b);
                mul_a = MW'($signed({1'b0, alpha}));
                mul_b = MW'($signed({1'b0, tgy_reg}) - $signed({1'b0, cury_reg}));
            end
            ST_MOVE: begin
                cury_next = CUR_W'(PW'($signed({1'b0, cury_reg})) + r_b);
                push = 1'b1; push_kind = EV_MOVE;
                push_px = px_w[CUR_W-1:C];
                push_py = py_w[CUR_W-1:C];
            end
            ST_SCROLL: begin
                if (!primed_reg) begin
                    primed_next = 1'b1;
                end
                dy_next = d_sc;
                lscroll_next = iy_reg;
            end
            ST_WHEEL_MUL: begin mul_a = MW'(dy_reg); mul_b = MW'(WHEEL_MAX); end
            ST_WHEEL: begin
                push = 1'b1; push_kind = EV_WHEEL;
                if (r_b > PW'(WHEEL_MAX)) push_wh = WHEEL_W'(WHEEL_MAX);
                else if (r_b < -PW'(WHEEL_MAX)) push_wh = WHEEL_W'(-WHEEL_MAX);
                else push_wh = WHEEL_W'(r_b);
            end
            ST_OUT: begin
                if (m_acc) out_idx_next = ~out_idx_reg;
                if (state_next == ST_IDLE) out_idx_next = 1'b0;
            end
            default: begin end
        endcase

        ev_cnt_next = ev_cnt_reg;
        if (s_acc) ev_cnt_next = 2'd0;
        else if (push) ev_cnt_next = ev_cnt_reg + 2'd1;
        else if (state_reg == ST_OUT && state_next == ST_IDLE) ev_cnt_next = 2'd0;

        prod_next = mul_a * mul_b;
    end

    // pixel rounding of the cursor (x already updated, y on its way in)
    assign px_w = (CUR_W+1)'(curx_reg) + (CUR_W+1)'(1 << (C - 1));
    assign py_w = (CUR_W+1)'(cury_next) + (CUR_W+1)'(1 << (C - 1));

    // result word
    assign m_tuser = ev_kind_reg[out_idx_reg];
    assign m_tlast = out_last;
    assign m_tdata = OUT_W'({ev_wh_reg[out_idx_reg], ev_py_reg[out_idx_reg],
                             ev_px_reg[out_idx_reg]});

    // control and tracking registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            active_reg  <= MODE_IDLE;
            held_reg    <= 1'b0;
            freeze_reg  <= '0;
            first_reg   <= 1'b1;
            primed_reg  <= 1'b0;
            lscroll_reg <= '0;
            lrx_reg     <= '0;
            lry_reg     <= '0;
            curx_reg    <= '0;
            cury_reg    <= '0;
            ev_cnt_reg  <= 2'd0;
            out_idx_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            held_reg    <= held_next;
            freeze_reg  <= freeze_next;
            first_reg   <= first_next;
            primed_reg  <= primed_next;
            lscroll_reg <= lscroll_next;
            lrx_reg     <= lrx_next;
            lry_reg     <= lry_next;
            curx_reg    <= curx_next;
            cury_reg    <= cury_next;
            ev_cnt_reg  <= ev_cnt_next;
            out_idx_reg <= out_idx_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg  <= SCR_CFG_W'(1920);
            ch_reg  <= SCR_CFG_W'(1080);
            cen_reg <= DIST_CFG_W'(3277);
            cex_reg <= DIST_CFG_W'(5243);
            cph_reg <= HOLD_CFG_W'(200);
            crh_reg <= HOLD_CFG_W'(100);
            cdz_reg <= DIST_CFG_W'(786);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_SCREEN_WIDTH:  cw_reg  <= cfg_data[SCR_CFG_W-1:0];
                REG_SCREEN_HEIGHT: ch_reg  <= cfg_data[SCR_CFG_W-1:0];
                REG_PINCH_ENTER:   cen_reg <= cfg_data[DIST_CFG_W-1:0];
                REG_PINCH_EXIT:    cex_reg <= cfg_data[DIST_CFG_W-1:0];
                REG_PRESS_HOLD:    cph_reg <= cfg_data[HOLD_CFG_W-1:0];
                REG_RELEASE_HOLD:  crh_reg <= cfg_data[HOLD_CFG_W-1:0];
                REG_SCROLL_DEAD:   cdz_reg <= cfg_data[DIST_CFG_W-1:0];
                default: begin end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        mode_in_reg <= mode_in_next;
        ix_reg <= ix_next; iy_reg <= iy_next; tx_reg <= tx_next; ty_reg <= ty_next;
        iok_reg <= iok_next; tok_reg <= tok_next; now_reg <= now_next;
        prod_reg <= prod_next; sum_reg <= sum_next;
        dx_reg <= dx_next; dy_reg <= dy_next;
        m_reg <= m_next; rem_reg <= rem_next; rad_reg <= rad_next; cnt_reg <= cnt_next;
        t1x_reg <= t1x_next; t1y_reg <= t1y_next;
        tgx_reg <= tgx_next; tgy_reg <= tgy_next; lt_reg <= lt_next;
        if (push) begin
            ev_kind_reg[ev_cnt_reg[0]] <= push_kind;
            ev_px_reg[ev_cnt_reg[0]]   <= push_px;
            ev_py_reg[ev_cnt_reg[0]]   <= push_py;
            ev_wh_reg[ev_cnt_reg[0]]   <= push_wh;
        end
    end

    // checks
    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_cnt_reg != 2'd3) else $error("result buffer overflow");
    a_out_has_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (ev_cnt_reg != 2'd0)) else $error("result shown with empty buffer");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid) else $error("frame taken while results pending");
    a_push_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !s_tready) else $error("result pushed while idle");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import gpc_pkg::*;

    localparam int IN_W  = 104;
    localparam int OUT_W = 40;
    localparam longint ONE = 64'd65536;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE = 60;

    // one input frame as the predictor sees it
    typedef struct {
        logic [1:0]  mode;
        logic [16:0] ix, iy, tx, ty;
        logic        iok, tok;
        logic [31:0] now;
    } frame_t;

    // one pointer event word
    typedef struct {
        event_kind_t       kind;
        logic [12:0]       px, py;
        logic signed [9:0] wheel;
        logic              last;
    } ptr_event_t;

    // directed row: n_fixed < 0 means the predictor supplies the events
    typedef struct {
        frame_t            f;
        int                n_fixed;
        event_kind_t       kind;
        logic signed [9:0] wheel;
    } row_t;

    logic              aclk;
    logic              aresetn;
    logic [IN_W-1:0]   s_tdata;
    logic [1:0]        s_tuser;
    logic              s_tvalid;
    logic              s_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    gesture_pointer_controller_unit dut (.*);

    // frame currently on the bus, with its fixed expectation if any
    row_t s_row;

    // predictor copy of the configuration
    longint scr_w, scr_h, enter_d, exit_d, press_ms, release_ms, dead_zone;
    // predictor copy of the tracking state
    logic [1:0]  p_mode;
    logic        p_held, p_first, p_primed;
    logic [31:0] p_freeze;
    longint      p_scroll, p_rawx, p_rawy, p_curx, p_cury;

    ptr_event_t  pending_events[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          snd_idle = 0, rcv_idle = 0;

    // random walk state for the stimulus
    longint      walk_x = 32768, walk_y = 32768;
    logic [31:0] clock_ms = 32'd1000;
    logic [1:0]  walk_mode = MODE_CURSOR;
    logic        pinch_mood = 0;

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint round_shift(longint v, int s);
        longint mag;
        mag = v < 0 ? -v : v;
        mag = (mag + ((64'd1 << s) >> 1)) >>> s;
        return v < 0 ? -mag : mag;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // floor square root, one result bit per pass
    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned root, bit_w;
        root  = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= root + bit_w) begin
                v    = v - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    function automatic logic [31:0] deadline(logic [31:0] now, longint hold);
        logic [32:0] s;
        s = 33'({1'b0, now} + hold);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic ptr_event_t mk_event(event_kind_t k, longint px, longint py,
                                            longint wh);
        ptr_event_t e;
        e.kind  = k;
        e.px    = px[12:0];
        e.py    = py[12:0];
        e.wheel = wh[9:0];
        e.last  = 0;
        return e;
    endfunction

    // pointer behavior for one frame
    task automatic predict_frame(input frame_t f, output ptr_event_t ev[2], output int n);
        logic [1:0]  mode;
        longint      ix, iy, tx, ty, w, h, dx, dy, m, acc, alpha, tgx, tgy, d, wh;
        longint unsigned d2, m2;
        logic        ivalid, tvalid, frozen;
        n  = 0;
        ix = f.ix; iy = f.iy; tx = f.tx; ty = f.ty;
        ivalid = f.iok && ix <= ONE && iy <= ONE;
        tvalid = f.tok && tx <= ONE && ty <= ONE;
        mode   = (f.mode == MODE_SPARE) ? MODE_IDLE : f.mode;
        w = clip(scr_w, 1, 8192);
        h = clip(scr_h, 1, 8192);
        if (mode != p_mode) begin
            if (p_held) begin
                ev[n++] = mk_event(EV_BUTTON_UP, 0, 0, 0);
                p_held = 0;
            end
            p_mode   = mode;
            p_first  = 1;
            p_primed = 0;
        end
        if (!ivalid || p_mode == MODE_IDLE) begin
            if (p_held) begin
                ev[n++] = mk_event(EV_BUTTON_UP, 0, 0, 0);
                p_held = 0;
            end
        end else if (p_mode == MODE_CURSOR) begin
            // pinch hysteresis
            if (tvalid) begin
                dx = tx - ix; dy = ty - iy;
                d2 = dx * dx + dy * dy;
                if (d2 < enter_d * enter_d && !p_held) begin
                    ev[n++] = mk_event(EV_BUTTON_DOWN, 0, 0, 0);
                    p_held = 1;
                    p_freeze = deadline(f.now, press_ms);
                end else if (d2 > exit_d * exit_d && p_held) begin
                    ev[n++] = mk_event(EV_BUTTON_UP, 0, 0, 0);
                    p_held = 0;
                    p_freeze = deadline(f.now, release_ms);
                end
            end
            frozen = f.now < p_freeze;
            if (frozen || p_first) begin
                if (!frozen) begin
                    p_curx  = (w / 2) * 256;
                    p_cury  = (h / 2) * 256;
                    p_first = 0;
                end
                p_rawx = ix; p_rawy = iy;
            end else begin
                // accelerated, clamped and smoothed motion
                dx = ix - p_rawx; dy = iy - p_rawy;
                m2 = dx * dx + dy * dy;
                p_rawx = ix; p_rawy = iy;
                if (m2 * 4000000 >= (64'd1 << 32)) begin
                    m     = int_sqrt(m2);
                    acc   = ONE + 40 * m;
                    tgx   = round_shift(round_shift(dx * acc, 16) * 3 * w * 256, 17);
                    tgy   = round_shift(round_shift(dy * acc, 16) * 3 * h * 256, 17);
                    tgx   = clip(p_curx + tgx, 0, (w - 1) * 256);
                    tgy   = clip(p_cury + tgy, 0, (h - 1) * 256);
                    alpha = clip(15 * m, (15 * ONE + 50) / 100, ONE);
                    p_curx += round_shift(alpha * (tgx - p_curx), 16);
                    p_cury += round_shift(alpha * (tgy - p_cury), 16);
                    ev[n++] = mk_event(EV_MOVE, (p_curx + 128) >>> 8,
                                       (p_cury + 128) >>> 8, 0);
                end
            end
        end else begin
            // scroll: first frame only primes
            if (!p_primed) begin
                p_scroll = iy;
                p_primed = 1;
            end else begin
                d = p_scroll - iy;
                p_scroll = iy;
                if ((d < 0 ? -d : d) >= dead_zone) begin
                    wh = clip(round_shift(d * 480, 16), -WHEEL_MAX, WHEEL_MAX);
                    ev[n++] = mk_event(EV_WHEEL, 0, 0, wh);
                end
            end
        end
        if (n > 0) ev[n-1].last = 1;
    endtask

    // input acceptance, output checking and watchdog share one sampling point
    always @(posedge aclk) begin
        ptr_event_t ev[2];
        ptr_event_t got, want;
        int         n;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_frame(s_row.f, ev, n);
                if (s_row.n_fixed >= 0) begin
                    n = s_row.n_fixed;
                    if (n > 0) begin
                        ev[0] = mk_event(s_row.kind, 0, 0, s_row.wheel);
                        ev[0].last = 1;
                    end
                end
                for (int i = 0; i < n; i++) pending_events.push_back(ev[i]);
            end
            if (m_tvalid && m_tready) begin
                got.kind  = event_kind_t'(m_tuser);
                got.px    = m_tdata[12:0];
                got.py    = m_tdata[25:13];
                got.wheel = m_tdata[35:26];
                got.last  = m_tlast;
                if (pending_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected event: kind %s x %0d y %0d wheel %0d last %0d",
                                 got.kind.name(), got.px, got.py, got.wheel, got.last);
                end else begin
                    want = pending_events.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("event mismatch: exp %s x %0d y %0d wheel %0d last %0d, got %s x %0d y %0d wheel %0d last %0d",
                                     want.kind.name(), want.px, want.py, want.wheel,
                                     want.last, got.kind.name(), got.px, got.py,
                                     got.wheel, got.last);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT) begin
                $display("** gesture_pointer_controller_unit: FAILED **");
                $finish;
            end else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver back-pressure
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= rcv_idle);

    task automatic send_frame(input row_t r);
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_row    <= r;
        s_tuser  <= r.f.mode;
        s_tdata  <= {2'b0, r.f.now, r.f.tok, r.f.iok, r.f.ty, r.f.tx, r.f.iy, r.f.ix};
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // drain, then let any frame without events finish
    task automatic drain;
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input longint val);
        cfg_addr  <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        case (idx)
            REG_SCREEN_WIDTH:  scr_w      = val & 14'h3FFF;
            REG_SCREEN_HEIGHT: scr_h      = val & 14'h3FFF;
            REG_PINCH_ENTER:   enter_d    = val & 17'h1FFFF;
            REG_PINCH_EXIT:    exit_d     = val & 17'h1FFFF;
            REG_PRESS_HOLD:    press_ms   = val & 10'h3FF;
            REG_RELEASE_HOLD:  release_ms = val & 10'h3FF;
            REG_SCROLL_DEAD:   dead_zone  = val & 17'h1FFFF;
            default: ;
        endcase
    endtask

    task automatic write_all(input longint w, h, en, ex, pr, rl, dz);
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
        write_reg(REG_PINCH_ENTER, en);
        write_reg(REG_PINCH_EXIT, ex);
        write_reg(REG_PRESS_HOLD, pr);
        write_reg(REG_RELEASE_HOLD, rl);
        write_reg(REG_SCROLL_DEAD, dz);
    endtask

    function automatic longint step_coord(longint v);
        longint d;
        if ($urandom_range(9) == 0) return $urandom_range(65536);
        d = $urandom_range(2000);
        v = $urandom_range(1) ? v + d : v - d;
        return clip(v, 0, ONE);
    endfunction

    // mostly well-formed tracking frames, some noise
    function automatic row_t random_frame();
        row_t   r;
        longint off;
        r.n_fixed = -1;
        r.kind    = EV_MOVE;
        r.wheel   = 0;
        if ($urandom_range(99) < 5) walk_mode = 2'($urandom_range(3));
        if ($urandom_range(7) == 0) pinch_mood = ~pinch_mood;
        walk_x = step_coord(walk_x);
        walk_y = step_coord(walk_y);
        clock_ms += $urandom_range(60);
        if ($urandom_range(49) == 0) clock_ms += $urandom_range(2000);
        off = pinch_mood ? $urandom_range(4000) : $urandom_range(20000, 3000);
        r.f.mode = walk_mode;
        r.f.ix   = 17'(walk_x);
        r.f.iy   = 17'(walk_y);
        r.f.tx   = 17'(clip($urandom_range(1) ? walk_x + off : walk_x - off, 0, ONE));
        r.f.ty   = 17'(clip(walk_y + $urandom_range(1000) - 500, 0, ONE));
        r.f.iok  = $urandom_range(29) != 0;
        r.f.tok  = $urandom_range(19) != 0;
        r.f.now  = clock_ms;
        if ($urandom_range(99) == 0) begin
            r.f.mode = 2'($urandom);
            r.f.ix   = 17'($urandom);
            r.f.iy   = 17'($urandom);
            r.f.tx   = 17'($urandom);
            r.f.ty   = 17'($urandom);
            r.f.iok  = 1'($urandom);
            r.f.tok  = 1'($urandom);
            r.f.now  = $urandom;
        end
        return r;
    endfunction

    function automatic row_t mk_row(logic [1:0] md, longint ix, iy, tx, ty,
                                    logic iok, tok, logic [31:0] now,
                                    int nf, event_kind_t k, longint wh);
        row_t r;
        r.f.mode = md; r.f.ix = 17'(ix); r.f.iy = 17'(iy);
        r.f.tx = 17'(tx); r.f.ty = 17'(ty);
        r.f.iok = iok; r.f.tok = tok; r.f.now = now;
        r.n_fixed = nf; r.kind = k; r.wheel = 10'(wh);
        return r;
    endfunction

    row_t directed[$];

    initial begin
        aresetn   = 0;
        s_tvalid  = 0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 0;
        cfg_valid = 0;
        cfg_addr  = '0;
        cfg_data  = '0;
        s_row     = mk_row(MODE_IDLE, 0, 0, 0, 0, 0, 0, 0, 0, EV_MOVE, 0);
        scr_w = 1920; scr_h = 1080; enter_d = 3277; exit_d = 5243;
        press_ms = 200; release_ms = 100; dead_zone = 786;
        p_mode = MODE_IDLE; p_held = 0; p_freeze = 0; p_first = 1; p_primed = 0;
        p_scroll = 0; p_rawx = 0; p_rawy = 0; p_curx = 0; p_cury = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed frames under the reset configuration
        directed = '{
            mk_row(MODE_IDLE,   0, 0, 0, 0, 1, 1, 0, 0, EV_MOVE, 0),
            mk_row(MODE_SPARE,  65536, 65536, 65536, 65536, 1, 1, 5, 0, EV_MOVE, 0),
            // first cursor frame centers only
            mk_row(MODE_CURSOR, 32768, 32768, 0, 0, 1, 0, 1000, 0, EV_MOVE, 0),
            mk_row(MODE_CURSOR, 65536, 65536, 0, 0, 1, 0, 1010, -1, EV_MOVE, 0),
            mk_row(MODE_CURSOR, 0, 0, 0, 0, 1, 0, 1020, -1, EV_MOVE, 0),
            mk_row(MODE_CURSOR, 30000, 30000, 30000, 30000, 1, 1, 1030, 1,
                   EV_BUTTON_DOWN, 0),
            mk_row(MODE_CURSOR, 31000, 30000, 31000, 30000, 1, 1, 1100, 0, EV_MOVE, 0),
            mk_row(MODE_CURSOR, 30000, 30000, 65536, 65536, 1, 1, 1300, 1,
                   EV_BUTTON_UP, 0),
            mk_row(MODE_CURSOR, 30000, 30000, 30100, 30000, 1, 1, 1500, 1,
                   EV_BUTTON_DOWN, 0),
            // mode change releases, then scroll primes
            mk_row(MODE_SCROLL, 0, 0, 0, 0, 1, 1, 1510, 1, EV_BUTTON_UP, 0),
            mk_row(MODE_SCROLL, 0, 65536, 0, 0, 1, 1, 1520, 1, EV_WHEEL, -480),
            mk_row(MODE_SCROLL, 0, 0, 0, 0, 1, 1, 1530, 1, EV_WHEEL, 480),
            mk_row(MODE_SCROLL, 0, 100, 0, 0, 1, 1, 1540, 0, EV_MOVE, 0),
            mk_row(MODE_SCROLL, 0, 786, 0, 0, 1, 1, 1545, -1, EV_MOVE, 0),
            // coordinate above one invalidates the index
            mk_row(MODE_SCROLL, 131071, 0, 0, 0, 1, 1, 1550, 0, EV_MOVE, 0),
            mk_row(MODE_CURSOR, 10000, 10000, 0, 0, 0, 1, 1560, 0, EV_MOVE, 0),
            // invalid thumb: no pinch, motion still frozen
            mk_row(MODE_CURSOR, 10000, 10000, 131071, 10000, 1, 1, 1570, 0, EV_MOVE, 0),
            // deadline saturates near the top of the clock
            mk_row(MODE_CURSOR, 20000, 20000, 20000, 20000, 1, 1, 32'hFFFF_FFF0, 1,
                   EV_BUTTON_DOWN, 0),
            mk_row(MODE_CURSOR, 20000, 20000, 65536, 0, 1, 1, 32'hFFFF_FFFF, -1,
                   EV_MOVE, 0),
            mk_row(MODE_CURSOR, 20000, 20000, 20000, 20000, 1, 1, 100, -1, EV_MOVE, 0),
            mk_row(MODE_CURSOR, 20000, 20000, 65536, 65536, 1, 1, 500, -1, EV_MOVE, 0),
            mk_row(MODE_CURSOR, 40000, 50000, 65536, 65536, 1, 1, 700, -1, EV_MOVE, 0),
            // invalid index releases a held button
            mk_row(MODE_CURSOR, 40000, 50000, 40000, 50000, 1, 1, 800, -1, EV_MOVE, 0),
            mk_row(MODE_CURSOR, 40000, 50000, 40000, 50000, 0, 1, 810, 1, EV_BUTTON_UP, 0),
            mk_row(MODE_IDLE,   1, 131071, 131071, 1, 1, 0, 820, 0, EV_MOVE, 0)
        };
        foreach (directed[i]) send_frame(directed[i]);
        drain();

        // three random-frame phases, each under its own configuration
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: write_all(8192, 2, 92682, 0, 0, 1023, 0);
                1: write_all(16383, 0, 6000, 9000, 1023, 0, 65536);
                default: write_all(1280, 720, 3277, 5243, 50, 30, 400);
            endcase
            snd_idle = (ph == 0) ? 30 : (ph == 1) ? 74 : 0;
            rcv_idle = (ph == 0) ? 74 : (ph == 1) ? 30 : 0;
            for (int i = 0; i < 475; i++) send_frame(random_frame());
            drain();
        end

        if (mismatches == 0 && pending_events.size() == 0)
            $display("** gesture_pointer_controller_unit: PASSED **");
        else
            $display("** gesture_pointer_controller_unit: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/gpc_pkg.sv
rtl/core/gesture_pointer_controller_unit.sv
tb/testbench.sv
